>>> hdl/tchp_pkg.sv
// Shared types, phase codes and helpers for the ClientHello parser.
`timescale 1ns / 1ps
`default_nettype none
package tchp_pkg;

  localparam int unsigned PhaseW = 5;
  localparam int unsigned FifoDepth = 4;

  localparam logic [PhaseW-1:0] PH_TYPE   = 5'd0;
  localparam logic [PhaseW-1:0] PH_MLEN0  = 5'd1;
  localparam logic [PhaseW-1:0] PH_MLEN1  = 5'd2;
  localparam logic [PhaseW-1:0] PH_MLEN2  = 5'd3;
  localparam logic [PhaseW-1:0] PH_VER0   = 5'd4;
  localparam logic [PhaseW-1:0] PH_VER1   = 5'd5;
  localparam logic [PhaseW-1:0] PH_RAND   = 5'd6;
  localparam logic [PhaseW-1:0] PH_SIDLEN = 5'd7;
  localparam logic [PhaseW-1:0] PH_SID    = 5'd8;
  localparam logic [PhaseW-1:0] PH_CLEN0  = 5'd9;
  localparam logic [PhaseW-1:0] PH_CLEN1  = 5'd10;
  localparam logic [PhaseW-1:0] PH_CIPH   = 5'd11;
  localparam logic [PhaseW-1:0] PH_CMPLEN = 5'd12;
  localparam logic [PhaseW-1:0] PH_CMP    = 5'd13;
  localparam logic [PhaseW-1:0] PH_EXTL0  = 5'd14;
  localparam logic [PhaseW-1:0] PH_EXTL1  = 5'd15;
  localparam logic [PhaseW-1:0] PH_EH0    = 5'd16;
  localparam logic [PhaseW-1:0] PH_EH1    = 5'd17;
  localparam logic [PhaseW-1:0] PH_EH2    = 5'd18;
  localparam logic [PhaseW-1:0] PH_EH3    = 5'd19;
  localparam logic [PhaseW-1:0] PH_BSKIP  = 5'd20;
  localparam logic [PhaseW-1:0] PH_L16H   = 5'd21;
  localparam logic [PhaseW-1:0] PH_L16L   = 5'd22;
  localparam logic [PhaseW-1:0] PH_VLEN   = 5'd23;
  localparam logic [PhaseW-1:0] PH_PAIRS  = 5'd24;
  localparam logic [PhaseW-1:0] PH_SNIT   = 5'd25;
  localparam logic [PhaseW-1:0] PH_SNILH  = 5'd26;
  localparam logic [PhaseW-1:0] PH_SNILL  = 5'd27;
  localparam logic [PhaseW-1:0] PH_SNIN   = 5'd28;
  localparam logic [PhaseW-1:0] PH_ALPNL  = 5'd29;
  localparam logic [PhaseW-1:0] PH_ALPNN  = 5'd30;
  localparam logic [PhaseW-1:0] PH_IGNORE = 5'd31;

  localparam logic [2:0] KIND_CIPHER  = 3'd0;
  localparam logic [2:0] KIND_EXT     = 3'd1;
  localparam logic [2:0] KIND_GROUP   = 3'd2;
  localparam logic [2:0] KIND_SIGALG  = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  localparam logic [15:0] EXT_SNI      = 16'h0000;
  localparam logic [15:0] EXT_GROUPS   = 16'h000a;
  localparam logic [15:0] EXT_SIGALGS  = 16'h000d;
  localparam logic [15:0] EXT_ALPN     = 16'h0010;
  localparam logic [15:0] EXT_VERSIONS = 16'h002b;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic        run_end;
    logic        parse_ok;
    logic        grease_seen;
    logic        sni_present;
    logic [15:0] tls_version;
    logic [7:0]  alpn_char_first;
    logic [7:0]  alpn_char_second;
    logic [7:0]  alpn_length;
    logic [14:0] cipher_count;
    logic [13:0] extension_count;
  } item_t;

  typedef struct packed {
    logic  list_valid;
    item_t list_item;
    logic  sum_valid;
    item_t sum_item;
  } push_t;

  function automatic logic is_grease(input logic [15:0] v);
    return (v & 16'h0f0f) == 16'h0a0a;
  endfunction

endpackage
`default_nettype wire

>>> hdl/tchp_if.sv
// Request channel interfaces for bytes in and parsed items out.
`timescale 1ns / 1ps
`default_nettype none
interface tchp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tchp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] value;
  logic        run_end;
  logic        parse_ok;
  logic        grease_seen;
  logic        sni_present;
  logic [15:0] tls_version;
  logic [7:0]  alpn_char_first;
  logic [7:0]  alpn_char_second;
  logic [7:0]  alpn_length;
  logic [14:0] cipher_count;
  logic [13:0] extension_count;
  modport source (output valid, output kind, output value, output run_end,
    output parse_ok, output grease_seen, output sni_present, output tls_version,
    output alpn_char_first, output alpn_char_second, output alpn_length,
    output cipher_count, output extension_count, input ready);
  modport sink (input valid, input kind, input value, input run_end,
    input parse_ok, input grease_seen, input sni_present, input tls_version,
    input alpn_char_first, input alpn_char_second, input alpn_length,
    input cipher_count, input extension_count, output ready);
endinterface
`default_nettype wire

>>> hdl/tls_client_hello_parser_core.sv
// Top level of the streaming ClientHello parser.
// Usage:
//   in_i carries one handshake byte per request with last_byte marking the
//   final byte of the buffer. out_o carries parsed items: ciphers, extension
//   types, groups and signature algorithms, and a summary item (run_end 1)
//   after the byte marked last.
//   A byte is parsed in the cycle it is accepted; its items are queued
//   and reach out_o in order. One byte is taken every cycle while the result
//   queue (four entries) has room for two items, so throughput is one byte
//   per cycle when out_o is drained; only the last byte may yield two items.
//   When the receiver stalls, items collect in the queue and in_i.ready drops
//   once fewer than two entries are free; nothing is lost.
//   Reset clears the parse state to expect a new type byte and empties the
//   queue. After each summary the parser returns to that same state.
//   If parse_ok is 0 on a summary, the items given for that message are void.
`timescale 1ns / 1ps
`default_nettype none
module tls_client_hello_parser_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tchp_in_if.sink     in_i,
  tchp_out_if.source  out_o
);

  tchp_pkg::push_t push;
  tchp_pkg::item_t head;
  logic            room;
  logic            accept;

  assign in_i.ready = room;
  assign accept = in_i.valid && room;

  tchp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .push_o      (push)
  );

  tchp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .room_o  (room),
    .valid_o (out_o.valid),
    .item_o  (head)
  );

  assign out_o.kind             = head.kind;
  assign out_o.value            = head.value;
  assign out_o.run_end          = head.run_end;
  assign out_o.parse_ok         = head.parse_ok;
  assign out_o.grease_seen      = head.grease_seen;
  assign out_o.sni_present      = head.sni_present;
  assign out_o.tls_version      = head.tls_version;
  assign out_o.alpn_char_first  = head.alpn_char_first;
  assign out_o.alpn_char_second = head.alpn_char_second;
  assign out_o.alpn_length      = head.alpn_length;
  assign out_o.cipher_count     = head.cipher_count;
  assign out_o.extension_count  = head.extension_count;

endmodule
`default_nettype wire

>>> hdl/tchp_parser.sv
// Byte-wise ClientHello parse state and item generation.
`timescale 1ns / 1ps
`default_nettype none
module tchp_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            last_byte_i,
  output tchp_pkg::push_t      push_o
);

  logic [4:0]  phase_q, phase_d;
  logic [23:0] mrem_q, mrem_d;
  logic [15:0] srem_q, srem_d;
  logic [15:0] xrem_q, xrem_d;
  logic [15:0] brem_q, brem_d;
  logic [15:0] irem_q, irem_d;
  logic [15:0] ext_q, ext_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] legacy_q, legacy_d;
  logic [15:0] best_q, best_d;
  logic [3:0]  flags_q, flags_d;
  logic [23:0] alpn_q, alpn_d;
  logic [14:0] ccnt_q, ccnt_d;
  logic [13:0] ecnt_q, ecnt_d;

  always_comb begin
    logic [4:0]  ph;
    logic [23:0] mr;
    logic [15:0] sr, xr, br, ir, et, lv, bv, v;
    logic [7:0]  hb, b;
    logic [3:0]  fl;
    logic [23:0] al;
    logic [14:0] cc;
    logic [13:0] ec;
    logic        ev;
    logic [2:0]  ek;
    logic [15:0] eval;
    logic        ok;
    ph = phase_q; mr = mrem_q; sr = srem_q; xr = xrem_q; br = brem_q;
    ir = irem_q; et = ext_q; hb = hold_q; lv = legacy_q; bv = best_q;
    fl = flags_q; al = alpn_q; cc = ccnt_q; ec = ecnt_q;
    b = data_byte_i; v = '0;
    ev = 1'b0; ek = tchp_pkg::KIND_CIPHER; eval = '0;

    if (ph == tchp_pkg::PH_TYPE) begin
      if (b != tchp_pkg::HS_CLIENT_HELLO) begin
        fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
      end else begin
        ph = tchp_pkg::PH_MLEN0;
      end
    end else if (ph == tchp_pkg::PH_MLEN0) begin
      mr = {b, 16'h0000}; ph = tchp_pkg::PH_MLEN1;
    end else if (ph == tchp_pkg::PH_MLEN1) begin
      mr[15:8] = b; ph = tchp_pkg::PH_MLEN2;
    end else if (ph == tchp_pkg::PH_MLEN2) begin
      mr[7:0] = b; ph = tchp_pkg::PH_VER0;
      if (mr == '0) begin
        fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
      end
    end else if (ph == tchp_pkg::PH_IGNORE) begin
      if (fl[2] && !fl[3] && mr != '0) mr = mr - 24'd1;
    end else begin
      if (mr != '0) mr = mr - 24'd1;
      if (ph >= tchp_pkg::PH_EH0 && xr != '0) xr = xr - 16'd1;
      if (ph >= tchp_pkg::PH_BSKIP && br != '0) br = br - 16'd1;
      case (ph)
        tchp_pkg::PH_VER0: begin
          hb = b; ph = tchp_pkg::PH_VER1;
        end
        tchp_pkg::PH_VER1: begin
          lv = {hb, b}; sr = 16'd32; ph = tchp_pkg::PH_RAND;
        end
        tchp_pkg::PH_RAND: begin
          sr = sr - 16'd1;
          if (sr == '0) ph = tchp_pkg::PH_SIDLEN;
        end
        tchp_pkg::PH_SIDLEN: begin
          if ({16'h0000, b} > mr) begin
            fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
          end else begin
            sr = {8'h00, b};
            ph = (b == '0) ? tchp_pkg::PH_CLEN0 : tchp_pkg::PH_SID;
          end
        end
        tchp_pkg::PH_SID: begin
          sr = sr - 16'd1;
          if (sr == '0) ph = tchp_pkg::PH_CLEN0;
        end
        tchp_pkg::PH_CLEN0: begin
          hb = b; ph = tchp_pkg::PH_CLEN1;
        end
        tchp_pkg::PH_CLEN1: begin
          v = {hb, b};
          if ({8'h00, v} > mr || v[0]) begin
            fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
          end else begin
            sr = v;
            ph = (v == '0) ? tchp_pkg::PH_CMPLEN : tchp_pkg::PH_CIPH;
          end
        end
        tchp_pkg::PH_CIPH: begin
          sr = sr - 16'd1;
          if (sr[0]) begin
            hb = b;
          end else begin
            v = {hb, b};
            if (tchp_pkg::is_grease(v)) begin
              fl[0] = 1'b1;
            end else begin
              ev = 1'b1; ek = tchp_pkg::KIND_CIPHER; eval = v;
              if (cc != '1) cc = cc + 15'd1;
            end
          end
          if (sr == '0) ph = tchp_pkg::PH_CMPLEN;
        end
        tchp_pkg::PH_CMPLEN: begin
          if ({16'h0000, b} > mr) begin
            fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
          end else begin
            sr = {8'h00, b};
            ph = (b == '0) ? tchp_pkg::PH_EXTL0 : tchp_pkg::PH_CMP;
          end
        end
        tchp_pkg::PH_CMP: begin
          sr = sr - 16'd1;
          if (sr == '0) ph = tchp_pkg::PH_EXTL0;
        end
        tchp_pkg::PH_EXTL0: begin
          hb = b; ph = tchp_pkg::PH_EXTL1;
        end
        tchp_pkg::PH_EXTL1: begin
          v = {hb, b};
          if ({8'h00, v} > mr) begin
            fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
          end else begin
            xr = v;
            if (xr == '0) begin
              fl[2] = 1'b1; ph = tchp_pkg::PH_IGNORE;
            end else if (xr < 16'd4) begin
              fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
            end else begin
              ph = tchp_pkg::PH_EH0;
            end
          end
        end
        tchp_pkg::PH_EH0: begin
          hb = b; ph = tchp_pkg::PH_EH1;
        end
        tchp_pkg::PH_EH1: begin
          et = {hb, b}; ph = tchp_pkg::PH_EH2;
        end
        tchp_pkg::PH_EH2: begin
          hb = b; ph = tchp_pkg::PH_EH3;
        end
        tchp_pkg::PH_EH3: begin
          v = {hb, b};
          if (v > xr) begin
            fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
          end else begin
            br = v;
            ph = tchp_pkg::PH_BSKIP;
            if (tchp_pkg::is_grease(et)) begin
              fl[0] = 1'b1;
            end else begin
              ev = 1'b1; ek = tchp_pkg::KIND_EXT; eval = et;
              if (ec != '1) ec = ec + 14'd1;
              if (et == tchp_pkg::EXT_SNI) begin
                if (br >= 16'd5) ph = tchp_pkg::PH_L16H;
              end else if (et == tchp_pkg::EXT_GROUPS || et == tchp_pkg::EXT_SIGALGS ||
                           et == tchp_pkg::EXT_ALPN) begin
                if (br >= 16'd2) ph = tchp_pkg::PH_L16H;
              end else if (et == tchp_pkg::EXT_VERSIONS) begin
                if (br >= 16'd1) ph = tchp_pkg::PH_VLEN;
              end
            end
          end
        end
        tchp_pkg::PH_L16H: begin
          hb = b; ph = tchp_pkg::PH_L16L;
        end
        tchp_pkg::PH_L16L: begin
          v = {hb, b};
          ph = tchp_pkg::PH_BSKIP;
          if (v <= br) begin
            ir = v;
            if (et == tchp_pkg::EXT_SNI) begin
              ph = (ir < 16'd3) ? tchp_pkg::PH_BSKIP : tchp_pkg::PH_SNIT;
            end else if (et == tchp_pkg::EXT_ALPN) begin
              if (v != '0) ph = tchp_pkg::PH_ALPNL;
            end else if (!v[0] && v != '0) begin
              ph = tchp_pkg::PH_PAIRS;
            end
          end
        end
        tchp_pkg::PH_VLEN: begin
          ph = tchp_pkg::PH_BSKIP;
          if (!({8'h00, b} > br || b[0])) begin
            bv = '0;
            ir = {8'h00, b};
            if (b != '0) ph = tchp_pkg::PH_PAIRS;
          end
        end
        tchp_pkg::PH_PAIRS: begin
          if (ir != '0) ir = ir - 16'd1;
          if (ir[0]) begin
            hb = b;
          end else begin
            v = {hb, b};
            if (et == tchp_pkg::EXT_GROUPS) begin
              if (!tchp_pkg::is_grease(v)) begin
                ev = 1'b1; ek = tchp_pkg::KIND_GROUP; eval = v;
              end
            end else if (et == tchp_pkg::EXT_SIGALGS) begin
              ev = 1'b1; ek = tchp_pkg::KIND_SIGALG; eval = v;
            end else if (!tchp_pkg::is_grease(v) && v > bv) begin
              bv = v;
            end
          end
          if (ir == '0) ph = tchp_pkg::PH_BSKIP;
        end
        tchp_pkg::PH_SNIT: begin
          ir = ir - 16'd1; sr = {8'h00, b}; ph = tchp_pkg::PH_SNILH;
        end
        tchp_pkg::PH_SNILH: begin
          ir = ir - 16'd1; hb = b; ph = tchp_pkg::PH_SNILL;
        end
        tchp_pkg::PH_SNILL: begin
          ir = ir - 16'd1;
          v = {hb, b};
          if (v > ir) begin
            ph = tchp_pkg::PH_BSKIP;
          end else if (sr == '0) begin
            fl[1] = 1'b1; ph = tchp_pkg::PH_BSKIP;
          end else begin
            sr = v;
            if (v == '0) begin
              ph = (ir < 16'd3) ? tchp_pkg::PH_BSKIP : tchp_pkg::PH_SNIT;
            end else begin
              ph = tchp_pkg::PH_SNIN;
            end
          end
        end
        tchp_pkg::PH_SNIN: begin
          ir = ir - 16'd1;
          if (sr != '0) sr = sr - 16'd1;
          if (sr == '0) ph = (ir < 16'd3) ? tchp_pkg::PH_BSKIP : tchp_pkg::PH_SNIT;
        end
        tchp_pkg::PH_ALPNL: begin
          ir = ir - 16'd1;
          ph = tchp_pkg::PH_BSKIP;
          if ({8'h00, b} <= ir && al[7:0] == '0) begin
            al = {16'h0000, b};
            if (b != '0) begin
              sr = (b >= 8'd2) ? 16'd2 : 16'd1;
              hb = '0;
              ph = tchp_pkg::PH_ALPNN;
            end
          end
        end
        tchp_pkg::PH_ALPNN: begin
          if (hb == '0) al[15:8] = al[15:8] | b;
          else al[23:16] = al[23:16] | b;
          hb = hb + 8'd1;
          if (sr != '0) sr = sr - 16'd1;
          if (sr == '0) ph = tchp_pkg::PH_BSKIP;
        end
        default: begin
        end
      endcase
      if (ph >= tchp_pkg::PH_BSKIP && ph != tchp_pkg::PH_IGNORE && br == '0) begin
        if (xr == '0) begin
          fl[2] = 1'b1; ph = tchp_pkg::PH_IGNORE;
        end else if (xr < 16'd4) begin
          fl[3] = 1'b1; ph = tchp_pkg::PH_IGNORE;
        end else begin
          ph = tchp_pkg::PH_EH0;
        end
      end
      if (mr == '0 && ph != tchp_pkg::PH_IGNORE) begin
        if (ph == tchp_pkg::PH_EXTL0) fl[2] = 1'b1;
        else fl[3] = 1'b1;
        ph = tchp_pkg::PH_IGNORE;
      end
    end

    ok = fl[2] && !fl[3] && mr == '0;
    push_o = '0;
    push_o.list_valid = accept_i && ev;
    push_o.list_item.kind = ek;
    push_o.list_item.value = eval;
    push_o.sum_valid = accept_i && last_byte_i;
    push_o.sum_item.kind = tchp_pkg::KIND_SUMMARY;
    push_o.sum_item.run_end = 1'b1;
    push_o.sum_item.parse_ok = ok;
    push_o.sum_item.grease_seen = fl[0];
    push_o.sum_item.sni_present = fl[1];
    push_o.sum_item.tls_version = (bv != '0) ? bv : lv;
    push_o.sum_item.alpn_char_first = al[15:8];
    push_o.sum_item.alpn_char_second = al[23:16];
    push_o.sum_item.alpn_length = al[7:0];
    push_o.sum_item.cipher_count = cc;
    push_o.sum_item.extension_count = ec;

    phase_d = ph; mrem_d = mr; srem_d = sr; xrem_d = xr; brem_d = br;
    irem_d = ir; ext_d = et; hold_d = hb; legacy_d = lv; best_d = bv;
    flags_d = fl; alpn_d = al; ccnt_d = cc; ecnt_d = ec;
    if (last_byte_i) begin
      phase_d = tchp_pkg::PH_TYPE;
      mrem_d = '0; srem_d = '0; xrem_d = '0; brem_d = '0; irem_d = '0;
      ext_d = '0; hold_d = '0; legacy_d = '0; best_d = '0;
      flags_d = '0; alpn_d = '0; ccnt_d = '0; ecnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tchp_pkg::PH_TYPE;
      mrem_q <= '0; srem_q <= '0; xrem_q <= '0; brem_q <= '0; irem_q <= '0;
      ext_q <= '0; hold_q <= '0; legacy_q <= '0; best_q <= '0;
      flags_q <= '0; alpn_q <= '0; ccnt_q <= '0; ecnt_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      mrem_q <= mrem_d; srem_q <= srem_d; xrem_q <= xrem_d; brem_q <= brem_d;
      irem_q <= irem_d; ext_q <= ext_d; hold_q <= hold_d; legacy_q <= legacy_d;
      best_q <= best_d; flags_q <= flags_d; alpn_q <= alpn_d;
      ccnt_q <= ccnt_d; ecnt_q <= ecnt_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tchp_fifo.sv
// Result queue taking up to two items per cycle and giving one.
`timescale 1ns / 1ps
`default_nettype none
module tchp_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tchp_pkg::push_t  push_i,
  input  wire logic             pop_i,
  output logic                  room_o,
  output logic                  valid_o,
  output tchp_pkg::item_t       item_o
);

  localparam int unsigned PtrW = $clog2(tchp_pkg::FifoDepth);

  tchp_pkg::item_t mem_q [tchp_pkg::FifoDepth];
  logic [PtrW-1:0] wp_q, rp_q, wp_b;
  logic [PtrW:0]   cnt_q;
  logic            pop;

  assign valid_o = cnt_q != '0;
  assign pop     = pop_i && valid_o;
  assign room_o  = cnt_q <= (PtrW+1)'(tchp_pkg::FifoDepth - 2);
  assign item_o  = mem_q[rp_q];
  assign wp_b    = wp_q + PtrW'(push_i.list_valid);

  always_ff @(posedge clk_i) begin
    if (push_i.list_valid) mem_q[wp_q] <= push_i.list_item;
    if (push_i.sum_valid) mem_q[wp_b] <= push_i.sum_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_b + PtrW'(push_i.sum_valid);
      rp_q  <= rp_q + PtrW'(pop);
      cnt_q <= cnt_q + (PtrW+1)'(push_i.list_valid) + (PtrW+1)'(push_i.sum_valid)
               - (PtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire
